@@ hw/rtl/tmtw_pkg.sv @@
package tmtw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Widths: column and row can reach their limit for one step before wrap
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = $clog2(CELLS);

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int CADR_W = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 4;

  // Request codes
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Control bytes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CHAR_W-1:0]  RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0]  RESET_CELL = {RESET_ATTR, CH_SPACE};
  localparam logic [ATTR_W-1:0]  ATTR_RESET = 4'd7;

endpackage

@@ hw/rtl/tmtw_req_if.sv @@
interface tmtw_req_if import tmtw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CHAR_W-1:0] char_code;
  logic [CADR_W-1:0] cell_address;
  logic              end_of_text;

  modport source (output valid, output req_type, output char_code,
                  output cell_address, output end_of_text, input ready);
  modport sink   (input valid, input req_type, input char_code,
                  input cell_address, input end_of_text, output ready);
endinterface

@@ hw/rtl/tmtw_rsp_if.sv @@
interface tmtw_rsp_if import tmtw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CADR_W-1:0] cursor_position;
  logic              cursor_update;
  logic [CELL_W-1:0] read_cell;

  modport source (output valid, output cursor_position, output cursor_update,
                  output read_cell, input ready);
  modport sink   (input valid, input cursor_position, input cursor_update,
                  input read_cell, output ready);
endinterface

@@ hw/rtl/text_mode_terminal_writer.sv @@
// Text terminal of ROWS x COLUMNS cells held in one synchronous RAM with a
// cursor. Each request beat gives exactly one response beat. A put of a
// plain or control byte is answered from the response register; a read
// waits in S_READ for the registered RAM read. A put that runs past the
// last row scrolls: the RAM is copied up one row through its single write
// port, one cell a cycle, then the bottom row is zero-filled before the
// next request is taken. After reset a clearing pass writes every cell to
// 0x0F20 while no request is taken; attribute writes are taken at any
// time. The response register decouples the sides, so a new request is
// taken while the previous response is being drained.
module text_mode_terminal_writer
  import tmtw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              attr_we,
  input  logic [ATTR_W-1:0] attr_wdata,
  tmtw_req_if.sink          req,
  tmtw_rsp_if.source        rsp
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_ZFILL  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] scan;
  logic [ADDR_W-1:0] scan_next;
  logic              cp_valid;
  logic [ADDR_W-1:0] cp_addr;
  logic [ATTR_W-1:0] text_attribute;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [POS_W-1:0]  pos;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [POS_W-1:0]  pos_next;

  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] rdata;
  logic              rd_oob;

  logic              out_valid;
  logic [CADR_W-1:0] out_pos;
  logic              out_upd;
  logic [CELL_W-1:0] out_cell;
  logic              load;
  logic [CADR_W-1:0] load_pos;
  logic              load_upd;
  logic [CELL_W-1:0] load_cell;

  logic              accept;
  logic              is_put;
  logic              is_plain;
  logic [COL_W-1:0]  c1;
  logic [ROW_W-1:0]  r1;
  logic [POS_W-1:0]  p1;
  logic              wrap;
  logic              scroll;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign is_put    = (req.req_type == REQ_PUT);
  assign is_plain  = (req.char_code != CH_NEWLINE) && (req.char_code != CH_BACKSPACE)
                     && (req.char_code != CH_RETURN);

  // Cursor step for one put byte
  always_comb begin
    c1 = col;
    r1 = row;
    p1 = pos;
    priority if (req.char_code == CH_NEWLINE) begin
      c1 = '0;
      r1 = row + ROW_W'(1);
      p1 = pos + POS_W'(COLUMNS) - POS_W'(col);
    end else if (req.char_code == CH_BACKSPACE) begin
      if (col != '0) begin
        c1 = col - COL_W'(1);
        p1 = pos - POS_W'(1);
      end
    end else if (req.char_code == CH_RETURN) begin
      c1 = '0;
      p1 = pos - POS_W'(col);
    end else begin
      c1 = col + COL_W'(1);
      p1 = pos + POS_W'(1);
    end
    wrap = (c1 == COL_W'(COLUMNS));
    if (wrap) begin
      c1 = '0;
      r1 = r1 + ROW_W'(1);
    end
    scroll = (r1 == ROW_W'(ROWS));
    if (scroll) begin
      c1 = '0;
      r1 = ROW_W'(ROWS - 1);
      p1 = POS_W'((ROWS - 1) * COLUMNS);
    end
  end

  // Sequencer: clearing pass, idle, read wait, row copy, bottom fill
  always_comb begin
    state_next = state;
    scan_next  = scan;
    col_next   = col;
    row_next   = row;
    pos_next   = pos;
    mem_we     = 1'b0;
    mem_waddr  = scan;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = ADDR_W'(req.cell_address);
    load       = 1'b0;
    load_pos   = CADR_W'(pos);
    load_upd   = 1'b0;
    load_cell  = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        scan_next = scan + ADDR_W'(1);
        if (scan == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && is_put) begin
          mem_we    = is_plain;
          mem_waddr = ADDR_W'(pos);
          mem_wdata = {{(CHAR_W - ATTR_W){1'b0}}, text_attribute, req.char_code};
          col_next  = c1;
          row_next  = r1;
          pos_next  = p1;
          load      = 1'b1;
          load_pos  = CADR_W'(p1);
          load_upd  = req.end_of_text;
          if (scroll) begin
            scan_next  = '0;
            state_next = S_SCROLL;
          end
        end else if (accept) begin
          mem_re     = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        load      = 1'b1;
        load_cell = rd_oob ? '0 : rdata;
        state_next = S_IDLE;
      end
      S_SCROLL: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(scan + ADDR_W'(COLUMNS));
        mem_we    = cp_valid;
        mem_waddr = cp_addr;
        mem_wdata = rdata;
        scan_next = scan + ADDR_W'(1);
        if (scan == ADDR_W'(CELLS - COLUMNS - 1)) begin
          state_next = S_ZFILL;
        end
      end
      S_ZFILL: begin
        mem_we = 1'b1;
        if (cp_valid) begin
          mem_waddr = cp_addr;
          mem_wdata = rdata;
        end else begin
          scan_next = scan + ADDR_W'(1);
          if (scan == ADDR_W'(CELLS - 1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
        scan_next  = '0;
      end
    endcase
  end

  // Control state and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      scan           <= '0;
      cp_valid       <= 1'b0;
      col            <= '0;
      row            <= '0;
      pos            <= '0;
      text_attribute <= ATTR_RESET;
      out_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      scan     <= scan_next;
      cp_valid <= (state == S_SCROLL);
      col      <= col_next;
      row      <= row_next;
      pos      <= pos_next;
      if (attr_we) begin
        text_attribute <= attr_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold copy address and response payload
  always_ff @(posedge clk) begin
    cp_addr <= scan;
    if (accept) begin
      rd_oob <= (req.cell_address >= CADR_W'(CELLS));
    end
    if (load) begin
      out_pos  <= load_pos;
      out_upd  <= load_upd;
      out_cell <= load_cell;
    end
  end

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.cursor_position = out_pos;
  assign rsp.cursor_update   = out_upd;
  assign rsp.read_cell       = out_cell;

endmodule
